/* hw/rtl/qr_rs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qr_rs_pkg
// Shared types, constants and GF(256) helpers for the QR Reed-Solomon
// correction-byte generator.
// ----------------------------------------------------------------------------
package qr_rs_pkg;

   // Correction byte counts never exceed 30, so five bits cover every count
   localparam int ECC_CNT_W = 5;
   localparam int ROM_COUNT = 13;

   // Field polynomial x^8+x^4+x^3+x^2+1
   localparam logic [8:0] FIELD_POLY = 9'h11D;

   // Standard QR correction byte counts, one per generator
   localparam logic [ECC_CNT_W-1:0] ECC_COUNT_ROM [ROM_COUNT] = '{
      5'd7, 5'd10, 5'd13, 5'd15, 5'd16, 5'd17, 5'd18,
      5'd20, 5'd22, 5'd24, 5'd26, 5'd28, 5'd30
   };

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic                 load;   // latch feedback, pre-shift remainder
      logic                 sweep;  // one tap update through the multiplier
      logic                 shift;  // shift one correction byte out
      logic [ECC_CNT_W-1:0] tap;    // tap position during a sweep
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [ECC_CNT_W-1:0] ecc_count;
   } status_type;

   // GF(256) multiply, shift-and-add over the eight bits of b
   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [8:0] x;
      logic [7:0] acc;
      x   = {1'b0, a};
      acc = 8'd0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ x[7:0];
         end
         x = {x[7:0], 1'b0};
         if (x[8]) begin
            x = x ^ FIELD_POLY;
         end
      end
      return acc;
   endfunction

   // Coefficient of x^k in (x - 2^0)(x - 2^1)...(x - 2^(n-1));
   // elaboration use only
   function automatic logic [7:0] gen_coef(int n, int k);
      logic [7:0] c [32];
      logic [7:0] root;
      for (int i = 0; i < 32; i++) begin
         c[i] = 8'd0;
      end
      c[0] = 8'd1;
      root = 8'd1;
      for (int i = 0; i < n; i++) begin
         for (int kk = i + 1; kk >= 1; kk--) begin
            c[kk] = c[kk-1] ^ gf_mul(c[kk], root);
         end
         c[0] = gf_mul(c[0], root);
         root = gf_mul(root, 8'd2);
      end
      return c[k];
   endfunction

endpackage

/* hw/rtl/qr_rs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qr_rs_ctrl
// Sequencer: accepts a data word, runs the tap sweep, then emits the
// correction words after the last data word of a block.
// ----------------------------------------------------------------------------
module qr_rs_ctrl
   import qr_rs_pkg::*;
#(
   parameter int MAX_ECC_BYTES = 30
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic       rsp_tlast,
   output cmd_type    cmd,
   input  status_type status
);

   localparam logic [ECC_CNT_W-1:0] LAST_TAP = ECC_CNT_W'(MAX_ECC_BYTES - 1);

   state_type            state_ff, state_in;
   logic [ECC_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 last_ff, last_in;
   logic                 req_acc;
   logic                 rsp_acc;
   logic                 emit_final;

   assign req_acc    = req_tvalid & req_tready;
   assign rsp_acc    = rsp_tvalid & rsp_tready;
   assign emit_final = (cnt_ff + ECC_CNT_W'(1)) == status.ecc_count;

   // Next state and counter
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_SWEEP;
               cnt_in   = '0;
               last_in  = req_tlast;
            end
         end
         ST_SWEEP: begin
            if (cnt_ff == LAST_TAP) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + ECC_CNT_W'(1);
            end
         end
         ST_EMIT: begin
            if (rsp_acc) begin
               if (emit_final) begin
                  state_in = ST_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + ECC_CNT_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tlast  = 1'b0;
      cmd        = '0;
      cmd.tap    = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            rsp_tlast  = emit_final;
            cmd.shift  = rsp_tready;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
      end
   end

   // An accepted word always starts a sweep
   assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff == ST_SWEEP)
      else $error("accepted word did not start a sweep");

   // Never take a data word while correction words are pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input ready while emitting");

   // Emission count stays below the selected correction count
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> cnt_ff < status.ecc_count)
      else $error("emission ran past the correction count");

   // The final correction word ends the emission
   assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp_tlast |=> state_ff == ST_IDLE)
      else $error("emission continued after the final word");

endmodule

/* hw/rtl/qr_rs_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qr_rs_datapath
// Remainder shift line, feedback register, generator ROM, selection
// register and the shared GF(256) multiplier.
// ----------------------------------------------------------------------------
module qr_rs_datapath
   import qr_rs_pkg::*;
#(
   parameter int MAX_ECC_BYTES   = 30,
   parameter int GENERATOR_COUNT = 13
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data,
   input  logic [7:0] data_byte,
   output logic [7:0] ecc_byte,
   input  cmd_type    cmd,
   output status_type status
);

   localparam int GEN_IDX_W  = (GENERATOR_COUNT > 1) ? $clog2(GENERATOR_COUNT) : 1;
   localparam int COEF_IDX_W = $clog2(MAX_ECC_BYTES);
   localparam logic [3:0] LAST_GEN = 4'(GENERATOR_COUNT - 1);

   logic [7:0]           rem_ff [MAX_ECC_BYTES];
   logic [7:0]           rem_in [MAX_ECC_BYTES];
   logic [7:0]           fb_ff, fb_in;
   logic [3:0]           sel_ff;
   logic [3:0]           sel_sat;
   logic [GEN_IDX_W-1:0] row;
   logic [ECC_CNT_W-1:0] ecc_n;
   logic [ECC_CNT_W-1:0] coef_full;
   logic [7:0]           coef;
   logic [7:0]           product;
   logic [7:0]           tail;

   logic [7:0]           gen_rom [GENERATOR_COUNT][MAX_ECC_BYTES];
   logic [ECC_CNT_W-1:0] row_n   [GENERATOR_COUNT];

   // Generator ROM: rows clamped to the remainder capacity
   for (genvar g = 0; g < GENERATOR_COUNT; g++) begin : g_row
      localparam int ROM_N = (int'(ECC_COUNT_ROM[g]) > MAX_ECC_BYTES) ?
                             MAX_ECC_BYTES : int'(ECC_COUNT_ROM[g]);
      assign row_n[g] = ECC_CNT_W'(ROM_N);
      for (genvar k = 0; k < MAX_ECC_BYTES; k++) begin : g_coef
         localparam logic [7:0] COEF = gen_coef(ROM_N, k);
         assign gen_rom[g][k] = COEF;
      end
   end

   // Saturate the selection and look up the correction count
   assign sel_sat       = (sel_ff >= 4'(GENERATOR_COUNT)) ? LAST_GEN : sel_ff;
   assign row           = sel_sat[GEN_IDX_W-1:0];
   assign ecc_n         = row_n[row];
   assign status.ecc_count = ecc_n;

   // One tap: coefficient of x^(n-1-tap) times the feedback
   assign coef_full = ecc_n - ECC_CNT_W'(1) - cmd.tap;
   assign coef      = gen_rom[row][coef_full[COEF_IDX_W-1:0]];
   assign product   = gf_mul(fb_ff, coef);

   // New remainder entry for this tap; entries at or past n drop to zero
   always_comb begin
      tail = 8'd0;
      if ((cmd.tap + ECC_CNT_W'(1)) < ecc_n) begin
         tail = rem_ff[0];
      end
      if (cmd.tap < ecc_n) begin
         tail = tail ^ product;
      end
   end

   // Shift line update
   always_comb begin
      fb_in = fb_ff;
      for (int i = 0; i < MAX_ECC_BYTES; i++) begin
         rem_in[i] = rem_ff[i];
      end
      if (cmd.load || cmd.sweep || cmd.shift) begin
         for (int i = 0; i < MAX_ECC_BYTES - 1; i++) begin
            rem_in[i] = rem_ff[i+1];
         end
         rem_in[MAX_ECC_BYTES-1] = cmd.sweep ? tail : 8'd0;
      end
      if (cmd.load) begin
         fb_in = data_byte ^ rem_ff[0];
      end
   end

   assign ecc_byte = rem_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 4'd1;
         for (int i = 0; i < MAX_ECC_BYTES; i++) begin
            rem_ff[i] <= 8'd0;
         end
      end else begin
         if (csr_wr_en) begin
            sel_ff <= csr_wr_data;
         end
         for (int i = 0; i < MAX_ECC_BYTES; i++) begin
            rem_ff[i] <= rem_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      fb_ff <= fb_in;
   end

   // Commands are mutually exclusive
   assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.load, cmd.sweep, cmd.shift}) <= 1)
      else $error("overlapping datapath commands");

   // Correction count always comes from a valid row
   assert property (@(posedge clock) disable iff (reset)
      ecc_n != '0 && ecc_n <= ECC_CNT_W'(MAX_ECC_BYTES))
      else $error("correction count out of range");

   // A sweep tap never exceeds the remainder length
   assert property (@(posedge clock) disable iff (reset)
      cmd.sweep |-> cmd.tap < ECC_CNT_W'(MAX_ECC_BYTES))
      else $error("sweep tap past remainder");

endmodule

/* hw/rtl/qr_reed_solomon_ecc_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qr_reed_solomon_ecc_generator
// QR Reed-Solomon correction-byte generator over GF(256), poly 0x11D.
// ----------------------------------------------------------------------------
// Data words of one QR block enter on req_* one at a time, req_tlast on the
// last one. Each word is accepted (the load step), then swept one remainder
// tap at a time through a single shared GF(256) multiplier. After the last
// word the n correction words leave on rsp_*, highest order first, rsp_tlast
// on the final one, one per cycle while rsp_tready is high; the remainder is
// then clear for the next block.
// csr_wr_data selects the generator (7,10,13,15,16,17,18,20,22,24,26,28,30
// correction words; larger codes saturate); write it only while idle.
module qr_reed_solomon_ecc_generator
   import qr_rs_pkg::*;
#(
   parameter int MAX_ECC_BYTES   = 30,
   parameter int GENERATOR_COUNT = 13
) (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data,   // [3:0] ecc_set_index
   // data words in
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] data_byte
   input  logic       req_tlast,     // block_end
   // correction words out
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] ecc_byte
   output logic       rsp_tlast      // ecc_last
);

   cmd_type    cmd;
   status_type status;

   // Sequencer
   qr_rs_ctrl #(
      .MAX_ECC_BYTES (MAX_ECC_BYTES)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

   // Remainder datapath
   qr_rs_datapath #(
      .MAX_ECC_BYTES   (MAX_ECC_BYTES),
      .GENERATOR_COUNT (GENERATOR_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .data_byte   (req_tdata),
      .ecc_byte    (rsp_tdata),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

/* tb/qr_rs_ecc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qr_rs_ecc_checker
// Watches the data, correction and csr channels of the QR Reed-Solomon
// generator. It predicts the correction words of each block with its own
// GF(256) division and compares every correction word in order.
// ----------------------------------------------------------------------------
module qr_rs_ecc_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tlast,
   output int         fail_count,
   output int         pending
);

   localparam int REM_DEPTH = 30;
   localparam int GEN_SETS  = 13;

   typedef struct packed {
      logic [7:0] ecc_byte;
      logic       ecc_last;
   } ecc_word_type;

   ecc_word_type ecc_due [$];
   logic [7:0]   gen_taps [GEN_SETS][REM_DEPTH + 1];
   logic [7:0]   parity [REM_DEPTH];
   logic [3:0]   ecc_sel;

   // GF(256) product over x^8+x^4+x^3+x^2+1
   function automatic logic [7:0] gf_product(logic [7:0] a, logic [7:0] b);
      logic [8:0] x;
      logic [7:0] acc;
      x   = {1'b0, a};
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ x[7:0];
         end
         x = {x[7:0], 1'b0};
         if (x[8]) begin
            x = x ^ 9'h11D;
         end
      end
      return acc;
   endfunction

   // Correction word count of each generator slot
   function automatic int ecc_count_of(int slot);
      case (slot)
         0:       return 7;
         1:       return 10;
         2:       return 13;
         3:       return 15;
         4:       return 16;
         5:       return 17;
         6:       return 18;
         7:       return 20;
         8:       return 22;
         9:       return 24;
         10:      return 26;
         11:      return 28;
         default: return 30;
      endcase
   endfunction

   // Expand (x - 2^0)...(x - 2^(n-1)) once per slot
   initial begin : build_generators
      logic [7:0] c [REM_DEPTH + 1];
      logic [7:0] root;
      int         n;
      for (int s = 0; s < GEN_SETS; s++) begin
         n = ecc_count_of(s);
         for (int k = 0; k <= REM_DEPTH; k++) begin
            c[k] = 8'h00;
         end
         c[0] = 8'h01;
         root = 8'h01;
         for (int i = 0; i < n; i++) begin
            for (int k = i + 1; k >= 1; k--) begin
               c[k] = c[k-1] ^ gf_product(c[k], root);
            end
            c[0] = gf_product(c[0], root);
            root = gf_product(root, 8'h02);
         end
         for (int k = 0; k <= REM_DEPTH; k++) begin
            gen_taps[s][k] = c[k];
         end
      end
   end

   always @(posedge clock) begin : predict_and_compare
      logic [7:0]   fb;
      ecc_word_type want;
      int           slot;
      int           n;
      if (reset) begin
         ecc_due.delete();
         for (int i = 0; i < REM_DEPTH; i++) begin
            parity[i] = 8'h00;
         end
         ecc_sel    = 4'd1;
         fail_count = 0;
      end else begin
         // Track the generator selection
         if (csr_wr_en) begin
            ecc_sel = csr_wr_data;
         end

         // Advance the remainder by one data word
         if (req_tvalid && req_tready) begin
            slot = (ecc_sel >= GEN_SETS) ? GEN_SETS - 1 : int'(ecc_sel);
            n    = ecc_count_of(slot);
            fb   = req_tdata ^ parity[0];
            for (int i = 0; i + 1 < n; i++) begin
               parity[i] = parity[i+1] ^ gf_product(fb, gen_taps[slot][n-1-i]);
            end
            parity[n-1] = gf_product(fb, gen_taps[slot][0]);
            for (int i = n; i < REM_DEPTH; i++) begin
               parity[i] = 8'h00;
            end
            // Block end: queue the remainder, highest order first, then clear
            if (req_tlast) begin
               for (int i = 0; i < n; i++) begin
                  want.ecc_byte = parity[i];
                  want.ecc_last = (i == n - 1);
                  ecc_due.insert(ecc_due.size(), want);
               end
               for (int i = 0; i < REM_DEPTH; i++) begin
                  parity[i] = 8'h00;
               end
            end
         end

         // Compare each correction word with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (ecc_due.size() == 0) begin
               if (fail_count < 10) begin
                  $display("%0t: correction word with none due: byte %h last %b",
                           $realtime, rsp_tdata, rsp_tlast);
               end
               fail_count++;
            end else begin
               want = ecc_due.pop_front();
               if (rsp_tdata !== want.ecc_byte || rsp_tlast !== want.ecc_last) begin
                  if (fail_count < 10) begin
                     $display("%0t: ecc_byte exp %h got %h, ecc_last exp %b got %b",
                              $realtime, want.ecc_byte, rsp_tdata, want.ecc_last,
                              rsp_tlast);
                  end
                  fail_count++;
               end
            end
         end
      end
      pending = ecc_due.size();
   end

endmodule

/* tb/tb_qr_reed_solomon_ecc_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qr_reed_solomon_ecc_generator
// Drives QR data blocks into the Reed-Solomon generator under directed and
// random generator selections, with random gaps and output stalls, and
// leaves the checking of the correction words to the checker beside the block.
// ----------------------------------------------------------------------------
module tb_qr_reed_solomon_ecc_generator;

   // Margin after the last correction word for a word's sweep to finish
   localparam int SETTLE_CYCLES = 40;
   localparam int TARGET_WORDS  = 310;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [3:0] csr_wr_data = 4'd0;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'h00;
   logic       req_tlast   = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   int fail_count;
   int pending;
   int words_sent = 0;
   int sink_hold  = 0;
   bit sink_calm  = 1'b0;
   bit src_calm   = 1'b0;

   qr_reed_solomon_ecc_generator dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   qr_rs_ecc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one
   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 10) begin
         return 0;
      end else if (r < 18) begin
         return $urandom_range(1, 4);
      end
      return $urandom_range(10, 60);
   endfunction

   // Favor the ends of the range and the saturating codes
   function automatic logic [3:0] pick_index();
      case ($urandom_range(0, 5))
         0:       return 4'd0;
         1:       return 4'd12;
         2:       return 4'd15;
         default: return 4'($urandom_range(0, 15));
      endcase
   endfunction

   // Stall the correction channel, with calm stretches in between
   always @(negedge clock) begin
      if ($urandom_range(0, 299) == 0) begin
         sink_calm <= !sink_calm;
      end
      if (sink_hold > 0) begin
         sink_hold  <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!sink_calm && $urandom_range(0, 3) == 0) begin
            sink_hold <= gap_length();
         end
      end
   end

   // Offer one data word; called and returns at a falling edge
   task automatic push_word(input logic [7:0] data, input logic last);
      int gap;
      gap = src_calm ? 0 : gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do begin
         @(posedge clock);
      end while (!req_tready);
      words_sent++;
      @(negedge clock);
   endtask

   // Hold off until every correction word is out and the sweep is done
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_ecc_index(input logic [3:0] idx);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= idx;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      int len;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset selection, all-zero word
      push_word(8'h00, 1'b1);
      // Smallest generator, extreme data values
      set_ecc_index(4'd0);
      push_word(8'hFF, 1'b0);
      push_word(8'h80, 1'b0);
      push_word(8'h01, 1'b1);
      // Largest generator
      set_ecc_index(4'd12);
      push_word(8'hA5, 1'b1);
      // Index out of range saturates to the largest generator
      set_ecc_index(4'd15);
      push_word(8'hFF, 1'b0);
      push_word(8'h00, 1'b1);
      set_ecc_index(4'd13);
      push_word(8'h5A, 1'b1);
      // Selection shrinks mid-block: upper remainder entries drop
      set_ecc_index(4'd12);
      push_word(8'h3C, 1'b0);
      push_word(8'hC3, 1'b0);
      push_word(8'h7E, 1'b0);
      set_ecc_index(4'd0);
      push_word(8'h81, 1'b0);
      push_word(8'hFE, 1'b1);
      // Selection grows mid-block
      push_word(8'h55, 1'b0);
      push_word(8'hAA, 1'b0);
      set_ecc_index(4'd12);
      push_word(8'h0F, 1'b1);

      // Random blocks of random content
      while (words_sent < TARGET_WORDS) begin
         if ($urandom_range(0, 3) == 0) begin
            set_ecc_index(pick_index());
         end
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         src_calm = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < len; k++) begin
            if (k > 0 && $urandom_range(0, 29) == 0) begin
               set_ecc_index(pick_index());
            end
            push_word(8'($urandom_range(0, 255)), k == len - 1);
         end
         if ($urandom_range(0, 9) == 0) begin
            wait_idle();
         end
      end

      // Drain and give the verdict
      wait_idle();
      if (fail_count == 0 && pending == 0) begin
         $display("tb_qr_reed_solomon_ecc_generator: PASS");
      end else begin
         $display("tb_qr_reed_solomon_ecc_generator: FAIL");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #20_000_000;
      $display("tb_qr_reed_solomon_ecc_generator: FAIL");
      $finish;
   end

endmodule
